[rtl/bba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg: shared types and codes for the buddy block allocator
// status codes, op codes, the order range and the sequencer state type
// ----------------------------------------------------------------------------
package bba_pkg;

	// highest block order, the leaf count is 2^TOP_ORDER
	localparam int TOP_ORDER = 5;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_BIG  = 2'd1;
	localparam logic [1:0] ST_NO_BLOCK = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ORDER,
		S_DISPATCH,
		S_FIND,
		S_POP_RD,
		S_POP_WAIT,
		S_SPLIT,
		S_CHECK,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUSH,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

[rtl/buddy_block_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_block_allocator: buddy allocator over 2^TOP_ORDER leaf blocks
//
// s_axis beats carry one request: allocate (op 0) a block of size_bytes, or
// free (op 1) the block at block_index of size_bytes. Each request gives
// exactly one m_axis beat with status, granted leaf index and order.
// min_block_bytes is written on the cfg channel while the block is idle.
//
// a small sequencer drives one shared compare/shift unit and one free-list
// memory (one read or write a cycle). the size-to-order search tries one
// order at a time; an allocate then searches order by order for a free
// block and splits one order at a time, and S_DONE loads the result into
// the output register. a free walks the buddy's free list entry by entry
// for each merged order and shifts later entries down one at a time.
// s_axis_tready is low from acceptance until the result beat has been taken;
// while m_axis_tready is low the result waits in the output register and the
// next request is not taken.
// reset: order TOP_ORDER holds leaf 0, other lists empty, nothing allocated,
// min_block_bytes 255. the free-list memory needs no clearing (counts gate
// it, and the top-order list can only ever hold leaf 0, so what is read
// from it is not used)
module buddy_block_allocator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [11:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [15:0] size_bytes, [20:16] block_index, zero fill to 24
	input  wire logic [23:0] s_axis_tdata,
	// [0] op
	input  wire logic        s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [1:0] status, [6:2] granted_index, [9:7] granted_order, zero fill to 16
	output logic [15:0]      m_axis_tdata
);
	localparam int TOP_ORDER = bba_pkg::TOP_ORDER;
	localparam int NL = 1 << TOP_ORDER;
	localparam int NO = TOP_ORDER + 1;
	localparam int LW = TOP_ORDER;          // leaf index width
	localparam int OW = $clog2(NO + 1);     // order counter, holds NO
	localparam int OB = $clog2(NO);         // order index into per-order arrays
	localparam int CW = TOP_ORDER + 1;      // count, holds NL
	localparam int AW = $clog2(NO) + LW;    // memory address

	bba_pkg::state_t state_q, state_nx;

	logic [11:0]   min_q;
	logic          op_q;
	logic [15:0]   size_q;
	logic [4:0]    bidx_q;
	logic [OW-1:0] k_q, j_q;
	logic [LW-1:0] idx_q;
	logic [CW-1:0] i_q;
	logic [1:0]    status_q;
	logic [CW-1:0] cnt_q [NO];
	logic [NL-1:0] amap_q;
	logic [LW-1:0] mem [NO*NL];
	logic [LW-1:0] rd_s1;
	logic          ovalid_q;
	logic [15:0]   odata_q;

	// shared unit: capacity compare for one order
	logic [18:0] cap;
	logic        fits;
	assign cap  = {7'd0, min_q} << k_q;
	assign fits = cap >= {3'd0, size_q};

	logic [OB-1:0] jo, ko;
	assign jo = j_q[OB-1:0];
	assign ko = k_q[OB-1:0];
	logic [CW-1:0] cnt_j;
	assign cnt_j = cnt_q[jo];
	logic [LW:0] span;
	assign span = (LW+1)'(1) << k_q;
	logic [NL-1:0] span_mask;
	assign span_mask = NL'((({(NL+1){1'b0}} | (NL+1)'(1)) << span) - 1) << bidx_q;
	logic [LW-1:0] buddy;
	assign buddy = idx_q ^ LW'(span);

	// result fields: too-big gives order 0, alloc its own, free keeps it in j_q
	logic [2:0] res_order;
	logic [4:0] res_index;
	assign res_order = (status_q == bba_pkg::ST_TOO_BIG) ? 3'd0
	                 : (op_q == bba_pkg::OP_ALLOC) ? 3'(k_q) : 3'(j_q);
	assign res_index = (status_q == bba_pkg::ST_OK && op_q == bba_pkg::OP_ALLOC)
	                 ? 5'(idx_q) : 5'd0;

	assign cfg_ready     = (state_q == bba_pkg::S_IDLE);
	assign s_axis_tready = (state_q == bba_pkg::S_IDLE) && !ovalid_q;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = odata_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bba_pkg::S_IDLE:     if (s_axis_tvalid && s_axis_tready) state_nx = bba_pkg::S_ORDER;
			bba_pkg::S_ORDER:    if (fits) state_nx = bba_pkg::S_DISPATCH;
			                     else if (k_q == OW'(TOP_ORDER)) state_nx = bba_pkg::S_DONE;
			bba_pkg::S_DISPATCH: state_nx = (op_q == bba_pkg::OP_ALLOC) ? bba_pkg::S_FIND
			                                                            : bba_pkg::S_CHECK;
			bba_pkg::S_FIND:     if (cnt_j != '0) state_nx = bba_pkg::S_POP_RD;
			                     else if (j_q == OW'(TOP_ORDER)) state_nx = bba_pkg::S_DONE;
			bba_pkg::S_POP_RD:   state_nx = bba_pkg::S_POP_WAIT;
			bba_pkg::S_POP_WAIT: state_nx = bba_pkg::S_SPLIT;
			bba_pkg::S_SPLIT:    if (j_q == k_q) state_nx = bba_pkg::S_DONE;
			bba_pkg::S_CHECK:    state_nx = (bidx_q & LW'(span - 1)) != '0
			                                || (amap_q & span_mask) != span_mask
			                                ? bba_pkg::S_DONE : bba_pkg::S_SCAN_RD;
			bba_pkg::S_SCAN_RD:  if (k_q == OW'(TOP_ORDER) || i_q == cnt_q[ko])
			                         state_nx = bba_pkg::S_PUSH;
			                     else state_nx = bba_pkg::S_SCAN_CMP;
			bba_pkg::S_SCAN_CMP: state_nx = (rd_s1 == buddy) ? bba_pkg::S_SHIFT_RD
			                                                  : bba_pkg::S_SCAN_RD;
			bba_pkg::S_SHIFT_RD: state_nx = (i_q + 1'b1 >= cnt_q[ko]) ? bba_pkg::S_SCAN_RD
			                                                            : bba_pkg::S_SHIFT_WR;
			bba_pkg::S_SHIFT_WR: state_nx = bba_pkg::S_SHIFT_RD;
			bba_pkg::S_PUSH:     state_nx = bba_pkg::S_DONE;
			bba_pkg::S_DONE:     state_nx = bba_pkg::S_IDLE;
			default:             state_nx = bba_pkg::S_IDLE;
		endcase
	end

	// memory port: one read or one write a cycle
	logic          mwe;
	logic [AW-1:0] maddr;
	logic [LW-1:0] mwd;
	always_comb begin
		mwe = 1'b0;
		maddr = '0;
		mwd = '0;
		unique case (state_q)
			// count was already lowered in S_FIND, it now points at the top entry
			bba_pkg::S_POP_RD:   maddr = AW'(jo * NL) + AW'(cnt_j);
			bba_pkg::S_SPLIT:    if (j_q != k_q) begin
				mwe = cnt_q[jo - 1'b1] < CW'(NL);
				maddr = AW'((jo - 1'b1) * NL) + AW'(cnt_q[jo - 1'b1]);
				mwd = idx_q + LW'((LW+1)'(1) << (j_q - 1'b1));
			end
			bba_pkg::S_SCAN_RD:  maddr = AW'(ko * NL) + AW'(i_q);
			bba_pkg::S_SHIFT_RD: maddr = AW'(ko * NL) + AW'(i_q + 1'b1);
			bba_pkg::S_SHIFT_WR: begin
				mwe = 1'b1;
				maddr = AW'(ko * NL) + AW'(i_q);
				mwd = rd_s1;
			end
			bba_pkg::S_PUSH: begin
				mwe = cnt_q[ko] < CW'(NL);
				maddr = AW'(ko * NL) + AW'(cnt_q[ko]);
				mwd = idx_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mwe) mem[maddr] <= mwd;
		rd_s1 <= mem[maddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bba_pkg::S_IDLE;
			min_q    <= 12'd255;
			ovalid_q <= 1'b0;
			amap_q   <= '0;
			for (int o = 0; o < NO; o++) cnt_q[o] <= (o == TOP_ORDER) ? CW'(1) : '0;
			k_q <= '0; j_q <= '0; i_q <= '0; idx_q <= '0; status_q <= '0;
			op_q <= 1'b0; size_q <= '0; bidx_q <= '0; odata_q <= '0;
		end else begin
			state_q <= state_nx;
			if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			if (cfg_valid && cfg_ready) min_q <= cfg_data;
			unique case (state_q)
				bba_pkg::S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					op_q <= s_axis_tuser;
					size_q <= s_axis_tdata[15:0];
					bidx_q <= s_axis_tdata[20:16];
					k_q <= '0;
					status_q <= bba_pkg::ST_OK;
					idx_q <= '0;
				end
				bba_pkg::S_ORDER: if (fits) j_q <= k_q;
					else if (k_q == OW'(TOP_ORDER)) status_q <= bba_pkg::ST_TOO_BIG;
					else k_q <= k_q + 1'b1;
				bba_pkg::S_FIND: if (cnt_j != '0) cnt_q[jo] <= cnt_j - 1'b1;
					else if (j_q == OW'(TOP_ORDER)) status_q <= bba_pkg::ST_NO_BLOCK;
					else j_q <= j_q + 1'b1;
				// the top-order list only ever holds leaf 0
				bba_pkg::S_POP_WAIT: idx_q <= (j_q == OW'(TOP_ORDER)) ? '0 : rd_s1;
				bba_pkg::S_SPLIT: if (j_q != k_q) begin
					if (cnt_q[jo - 1'b1] < CW'(NL)) cnt_q[jo - 1'b1] <= cnt_q[jo - 1'b1] + 1'b1;
					j_q <= j_q - 1'b1;
				end else amap_q <= amap_q | (NL'((NL+1)'(1) << span) - 1'b1) << idx_q;
				bba_pkg::S_CHECK: begin
					idx_q <= bidx_q;
					i_q <= '0;
					if ((bidx_q & LW'(span - 1)) != '0 || (amap_q & span_mask) != span_mask)
						status_q <= bba_pkg::ST_NO_BLOCK;
					else amap_q <= amap_q & ~span_mask;
				end
				bba_pkg::S_SCAN_CMP: if (rd_s1 != buddy) i_q <= i_q + 1'b1;
				bba_pkg::S_SHIFT_RD: if (i_q + 1'b1 >= cnt_q[ko]) begin
					// removal done: merge up one order and restart scan
					cnt_q[ko] <= cnt_q[ko] - 1'b1;
					idx_q <= idx_q & ~LW'(span);
					k_q <= k_q + 1'b1;
					i_q <= '0;
				end
				bba_pkg::S_SHIFT_WR: i_q <= i_q + 1'b1;
				bba_pkg::S_PUSH: if (cnt_q[ko] < CW'(NL)) cnt_q[ko] <= cnt_q[ko] + 1'b1;
				bba_pkg::S_DONE: begin
					ovalid_q <= 1'b1;
					odata_q <= {6'd0, res_order, res_index, status_q};
				end
				default: ;
			endcase
			// free keeps original order for reporting in j_q
			if (state_q == bba_pkg::S_DISPATCH) j_q <= k_q;
		end
	end

endmodule
`default_nettype wire

[sim/bba_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker: free-list predictor and result scoreboard
// mirrors the free lists and allocation map, predicts each response beat
// and compares it field by field with what the allocator returns
// ----------------------------------------------------------------------------
module bba_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [11:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	output int          err_count,
	output int          resp_left
);

	localparam int TOP = bba_pkg::TOP_ORDER;
	localparam int LEAVES = 32;

	// lowest bits last, matching the beat layout
	typedef struct packed {
		logic [2:0] order;
		logic [4:0] index;
		logic [1:0] status;
	} resp_t;

	resp_t      resp_q[$];
	logic [11:0] leaf_bytes;
	int         lists[TOP+1][LEAVES];
	int         list_len[TOP+1];
	bit         taken[LEAVES];

	assign resp_left = resp_q.size();

	task automatic report(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		err_count++;
	endtask

	function automatic int fit_order(int sz);
		for (int k = 0; k <= TOP; k++) begin
			if ((int'(leaf_bytes) << k) >= sz)
				return k;
		end
		return -1;
	endfunction

	function automatic void push_free(int k, int idx);
		if (list_len[k] < LEAVES) begin
			lists[k][list_len[k]] = idx;
			list_len[k]++;
		end
	endfunction

	// remove idx from list k keeping the rest in order
	function automatic bit pull_free(int k, int idx);
		for (int i = 0; i < list_len[k]; i++) begin
			if (lists[k][i] == idx) begin
				for (int j = i; j < list_len[k] - 1; j++)
					lists[k][j] = lists[k][j+1];
				list_len[k]--;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic void mark(int idx, int k, bit v);
		for (int i = 0; i < (1 << k); i++)
			if (idx + i < LEAVES)
				taken[idx + i] = v;
	endfunction

	function automatic resp_t serve(logic op, int sz, int bidx);
		resp_t r;
		int k, j, idx, m, span;
		bit ok;
		r = '0;
		k = fit_order(sz);
		if (k < 0) begin
			r.status = bba_pkg::ST_TOO_BIG;
		end else if (op == bba_pkg::OP_ALLOC) begin
			r.order = 3'(k);
			j = k;
			while (j <= TOP && list_len[j] == 0)
				j++;
			if (j > TOP) begin
				r.status = bba_pkg::ST_NO_BLOCK;
			end else begin
				list_len[j]--;
				idx = lists[j][list_len[j]];
				// split down, upper halves go back on the free lists
				while (j > k) begin
					j--;
					push_free(j, idx + (1 << j));
				end
				mark(idx, k, 1);
				r.index = idx[4:0];
			end
		end else begin
			r.order = 3'(k);
			span = 1 << k;
			ok = (bidx & (span - 1)) == 0;
			for (int i = 0; ok && i < span; i++)
				if (bidx + i >= LEAVES || !taken[bidx + i])
					ok = 0;
			if (!ok) begin
				r.status = bba_pkg::ST_NO_BLOCK;
			end else begin
				idx = bidx;
				m = k;
				mark(idx, k, 0);
				// coalesce with free buddies
				while (m < TOP && pull_free(m, idx ^ (1 << m))) begin
					idx &= ~(1 << m);
					m++;
				end
				push_free(m, idx);
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		resp_t got, want;
		if (!arst_n) begin
			leaf_bytes = 12'd255;
			list_len = '{default: 0};
			taken = '{default: 0};
			lists[TOP][0] = 0;
			list_len[TOP] = 1;
			resp_q.delete();
			err_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[9:0];
				if (resp_q.size() == 0) begin
					report("unexpected beat", int'(got), 0);
				end else begin
					want = resp_q.pop_front();
					if (got.status !== want.status) report("status", got.status, want.status);
					if (got.index !== want.index) report("granted_index", got.index, want.index);
					if (got.order !== want.order) report("granted_order", got.order, want.order);
				end
			end
			// a leaf size written with a request on the same edge applies to it
			if (cfg_valid && cfg_ready)
				leaf_bytes = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				resp_q.push_back(serve(s_axis_tuser, int'(s_axis_tdata[15:0]),
					int'(s_axis_tdata[20:16])));
		end
	end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: buddy block allocator testbench
// directed requests, then random allocate/free traffic that tracks live
// blocks so most frees are legal, over several leaf sizes; checking lives
// in bba_checker
// ----------------------------------------------------------------------------
module tb;

	typedef struct {
		int idx;
		int ord;
	} blk_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [11:0] cfg_data = '0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [15:0] m_axis_tdata;
	int          err_count, resp_left;

	// sent ops waiting for their response, and blocks known to be held
	logic        op_q[$];
	blk_t        held[$];
	int          leaf_bytes = 255;
	bit          quiet = 0;
	int          stall_left = 0;

	always #5 clk = ~clk;

	buddy_block_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	bba_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.err_count(err_count), .resp_left(resp_left)
	);

	// receiver backpressure in random bursts
	always @(negedge clk) begin
		if (quiet) begin
			m_axis_tready = 1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready = (stall_left == 0);
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 8);
			m_axis_tready = 0;
		end else begin
			m_axis_tready = 1;
		end
	end

	// learn granted blocks from the response beats
	always @(posedge clk) begin
		blk_t b;
		logic op;
		if (m_axis_tvalid && m_axis_tready && op_q.size() > 0) begin
			op = op_q.pop_front();
			if (op == bba_pkg::OP_ALLOC && m_axis_tdata[1:0] == bba_pkg::ST_OK) begin
				b.idx = m_axis_tdata[6:2];
				b.ord = m_axis_tdata[9:7];
				held.push_back(b);
			end
		end
	end

	task automatic send(input logic op, input int sz, input int idx);
		s_axis_tuser = op;
		s_axis_tdata = {3'b000, idx[4:0], sz[15:0]};
		s_axis_tvalid = 1;
		#1;
		while (!s_axis_tready) begin
			@(negedge clk);
			#1;
		end
		@(negedge clk);
		op_q.push_back(op);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid = 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	endtask

	// wait for every response, then write the leaf size
	task automatic set_leaf(input int val);
		s_axis_tvalid = 0;
		while (op_q.size() > 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_data = val[11:0];
		cfg_valid = 1;
		#1;
		while (!cfg_ready) begin
			@(negedge clk);
			#1;
		end
		@(negedge clk);
		cfg_valid = 0;
		leaf_bytes = val;
	endtask

	// a size that rounds to order k, or -1 if none fits in 16 bits
	function automatic int size_for(int k);
		int lo, hi;
		lo = (k == 0) ? 0 : (leaf_bytes << (k - 1)) + 1;
		hi = leaf_bytes << k;
		if (hi > 65535) hi = 65535;
		if (lo > hi) return -1;
		return $urandom_range(lo, hi);
	endfunction

	task automatic random_item();
		int pick, k, sz, j, n;
		blk_t b, piece;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : $urandom_range(0, 2);
			sz = size_for(k);
			send(bba_pkg::OP_ALLOC, (sz < 0) ? $urandom_range(0, 65535) : sz,
				$urandom_range(0, 31));
		end else if (pick < 85 && held.size() > 0) begin
			n = $urandom_range(0, held.size() - 1);
			b = held[n];
			held.delete(n);
			k = b.ord;
			// sometimes release only the lower part, the rest stays held
			if (k > 0 && $urandom_range(0, 4) == 0) begin
				k = $urandom_range(0, b.ord - 1);
				for (j = k; j < b.ord; j++) begin
					piece.idx = b.idx + (1 << j);
					piece.ord = j;
					held.push_back(piece);
				end
			end
			sz = size_for(k);
			send(bba_pkg::OP_FREE, (sz < 0) ? $urandom_range(0, 65535) : sz, b.idx);
		end else begin
			send(1'($urandom_range(0, 1)), $urandom_range(0, 65535), $urandom_range(0, 31));
		end
	endtask

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed at reset leaf size 255
		send(bba_pkg::OP_ALLOC, 0, 31);          // size zero, full split chain
		send(bba_pkg::OP_ALLOC, 255, 0);         // exact fit order 0
		send(bba_pkg::OP_ALLOC, 256, 0);         // order 1
		send(bba_pkg::OP_ALLOC, 65535, 0);       // too large
		send(bba_pkg::OP_ALLOC, 8160, 0);        // order 5, nothing left to split
		send(bba_pkg::OP_FREE, 256, 1);          // misaligned free
		send(bba_pkg::OP_FREE, 1, 31);           // free of a block never granted
		send(bba_pkg::OP_FREE, 0, 0);            // legal free, buddy still held
		send(bba_pkg::OP_FREE, 65535, 0);        // free too large
		send(bba_pkg::OP_ALLOC, 1000, 0);        // order 2
		send(bba_pkg::OP_FREE, 255, 4);          // partial free of the order 2 block
		send(bba_pkg::OP_FREE, 510, 6);          // upper half of it, leaf 5 stays held
		send(bba_pkg::OP_FREE, 510, 2);          // order 1 block back, no merge as leaf 1 is held
		send(bba_pkg::OP_FREE, 255, 1);          // leaf 1 back, merges up to order 2

		// zero leaf size: only size zero fits
		set_leaf(0);
		send(bba_pkg::OP_ALLOC, 0, 0);
		send(bba_pkg::OP_ALLOC, 1, 0);
		send(bba_pkg::OP_FREE, 0, 0);
		send(bba_pkg::OP_FREE, 0, 0);            // same free again; leaf 0 is not held
		held.delete();

		set_leaf(1);
		repeat (110) random_item();
		set_leaf(4095);
		repeat (110) random_item();
		set_leaf(255);
		repeat (110) random_item();
		set_leaf($urandom_range(2, 4094));
		repeat (110) random_item();
		set_leaf($urandom_range(1, 64));
		repeat (100) random_item();
		quiet = 1;
		repeat (100) random_item();

		s_axis_tvalid = 0;
		while (op_q.size() > 0) @(negedge clk);
		repeat (400) @(negedge clk);
		if (err_count == 0 && resp_left == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[files.f]
rtl/bba_pkg.sv
rtl/buddy_block_allocator.sv
sim/bba_checker.sv
sim/tb.sv
